// File: rtl/fixed_point_alu_q24_8_assert.svh
// Assertion macros for the Q24.8 arithmetic unit.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef FIXED_POINT_ALU_Q24_8_ASSERT_SVH
`define FIXED_POINT_ALU_Q24_8_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fpa_pkg.sv
// Shared types and constants for the Q24.8 arithmetic unit.
// No dependencies.
`default_nettype none

package fpa_pkg;

  localparam int unsigned FRAC_BITS       = 8;
  localparam int unsigned DW              = 32;
  localparam int unsigned STEPS_PER_STAGE = 5;
  localparam int unsigned NUM_W           = DW + FRAC_BITS;
  localparam int unsigned DIV_STAGES      = (NUM_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int unsigned QW              = DIV_STAGES * STEPS_PER_STAGE;
  localparam int unsigned NUM_STAGES      = DIV_STAGES + 2;
  localparam int unsigned OVL_W           = DW + QW;

  typedef enum logic [3:0] {
    OP_ADD        = 4'd0,
    OP_SUB        = 4'd1,
    OP_MUL        = 4'd2,
    OP_DIV        = 4'd3,
    OP_GT         = 4'd4,
    OP_LT         = 4'd5,
    OP_GE         = 4'd6,
    OP_LE         = 4'd7,
    OP_EQ         = 4'd8,
    OP_NE         = 4'd9,
    OP_FROM_INT   = 4'd10,
    OP_FROM_FLOAT = 4'd11,
    OP_TO_FLOAT   = 4'd12,
    OP_TO_INT     = 4'd13
  } op_e;

  typedef struct packed {
    logic [3:0]        req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               divide_by_zero;
  } fpa_rsp_t;

  // Per-stage word. rem/num hold the divider state, the raw product for
  // multiply, or magnitude and MSB index for fixed-to-float.
  typedef struct packed {
    logic [3:0]    op;
    logic          neg;
    logic          dz;
    logic [DW-1:0] dvs;
    logic [DW-1:0] rem;
    logic [QW-1:0] num;
    logic [DW-1:0] res;
  } fpa_st_t;

endpackage

`default_nettype wire

// File: rtl/fpa_front.sv
// First stage logic: decode, simple ops, multiply, divider setup.
// Depends on fpa_pkg.
`default_nettype none

module fpa_front (
  input  fpa_pkg::fpa_req_t req_i,
  output fpa_pkg::fpa_st_t  st_o
);
  import fpa_pkg::*;

  logic [DW-1:0]      a_u, b_u, abs_a, abs_b, f2x;
  logic signed [63:0] prod;
  logic [4:0]         msb;
  logic               sgn;
  logic [7:0]         ex;
  logic [22:0]        fr;
  logic [63:0]        m64, mag;
  logic signed [9:0]  sh;
  logic [4:0]         rsh;

  assign a_u   = req_i.operand_a;
  assign b_u   = req_i.operand_b;
  assign abs_a = req_i.operand_a[31] ? (~a_u + DW'(1)) : a_u;
  assign abs_b = req_i.operand_b[31] ? (~b_u + DW'(1)) : b_u;
  assign prod  = req_i.operand_a * req_i.operand_b;

  always_comb begin
    msb = '0;
    for (int i = 0; i < DW; i++) begin
      if (abs_a[i]) msb = 5'(i);
    end
  end

  // Float bits to fixed, rounding half away from zero.
  always_comb begin
    sgn = a_u[31];
    ex  = a_u[30:23];
    fr  = a_u[22:0];
    m64 = {40'd0, 1'b1, fr};
    sh  = $signed({2'b00, ex}) - 10'sd150 + $signed(10'(FRAC_BITS));
    rsh = '0;
    mag = '0;
    if (sh > 10'sd40) begin
      mag = 64'h1_0000_0000;
    end else if (sh >= 10'sd0) begin
      mag = m64 << sh[5:0];
    end else if (sh < -10'sd25) begin
      mag = '0;
    end else begin
      rsh = 5'(-sh);
      mag = (m64 + (64'd1 << (rsh - 5'd1))) >> rsh;
    end
    if (ex == 8'hFF) begin
      f2x = (fr != '0) ? '0 : (sgn ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end else if (ex == 8'h00) begin
      f2x = '0;
    end else if (sgn) begin
      f2x = (mag >= 64'h8000_0000) ? 32'h8000_0000 : DW'(64'd0 - mag);
    end else begin
      f2x = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[DW-1:0];
    end
  end

  always_comb begin
    st_o    = '0;
    st_o.op = req_i.req_type;
    unique case (op_e'(req_i.req_type))
      OP_ADD:        st_o.res = a_u + b_u;
      OP_SUB:        st_o.res = a_u - b_u;
      OP_MUL:        {st_o.rem, st_o.num} = OVL_W'($unsigned(prod));
      OP_DIV: begin
        st_o.neg = req_i.operand_a[31] ^ req_i.operand_b[31];
        st_o.dz  = (b_u == '0);
        st_o.dvs = abs_b;
        st_o.num = QW'({abs_a, {FRAC_BITS{1'b0}}});
      end
      OP_GT:         st_o.res = {{(DW-1){1'b0}}, req_i.operand_a >  req_i.operand_b};
      OP_LT:         st_o.res = {{(DW-1){1'b0}}, req_i.operand_a <  req_i.operand_b};
      OP_GE:         st_o.res = {{(DW-1){1'b0}}, req_i.operand_a >= req_i.operand_b};
      OP_LE:         st_o.res = {{(DW-1){1'b0}}, req_i.operand_a <= req_i.operand_b};
      OP_EQ:         st_o.res = {{(DW-1){1'b0}}, req_i.operand_a == req_i.operand_b};
      OP_NE:         st_o.res = {{(DW-1){1'b0}}, req_i.operand_a != req_i.operand_b};
      OP_FROM_INT:   st_o.res = a_u << FRAC_BITS;
      OP_FROM_FLOAT: st_o.res = f2x;
      OP_TO_FLOAT: begin
        st_o.neg = req_i.operand_a[31];
        st_o.num = QW'(abs_a);
        st_o.rem = DW'(msb);
      end
      OP_TO_INT:     st_o.res = $unsigned(req_i.operand_a >>> FRAC_BITS);
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/fpa_pack.sv
// Second stage logic: product rescale and fixed-to-float round and pack.
// Depends on fpa_pkg.
`default_nettype none

module fpa_pack (
  input  fpa_pkg::fpa_st_t st_i,
  output fpa_pkg::fpa_st_t st_o
);
  import fpa_pkg::*;

  logic [OVL_W-1:0] ovl;
  logic [DW-1:0]    mag, norm;
  logic [4:0]       p;
  logic [23:0]      keep;
  logic             up;
  logic [24:0]      sum;
  logic [8:0]       expo;

  always_comb begin
    st_o = st_i;
    ovl  = {st_i.rem, st_i.num};
    mag  = st_i.num[DW-1:0];
    p    = st_i.rem[4:0];
    // Normalize MSB to bit 31, then round to nearest even on 24 bits.
    norm = mag << (5'd31 - p);
    keep = norm[31:8];
    up   = norm[7] & ((|norm[6:0]) | keep[0]);
    sum  = {1'b0, keep} + 25'(up);
    expo = 9'(p) + 9'(127 - FRAC_BITS) + 9'(sum[24]);
    if (st_i.op == OP_MUL) begin
      st_o.res = ovl[FRAC_BITS+DW-1:FRAC_BITS];
    end
    if (st_i.op == OP_TO_FLOAT) begin
      st_o.res = (mag == '0) ? '0
               : {st_i.neg, expo[7:0], (sum[24] ? 23'd0 : sum[22:0])};
    end
  end

endmodule

`default_nettype wire

// File: rtl/fpa_div_steps.sv
// One divider stage: a few restoring steps on the quotient/remainder word.
// Depends on fpa_pkg.
`default_nettype none

module fpa_div_steps (
  input  fpa_pkg::fpa_st_t st_i,
  output fpa_pkg::fpa_st_t st_o
);
  import fpa_pkg::*;

  logic [DW:0]   r2;
  logic [DW-1:0] rem;
  logic [QW-1:0] num;

  always_comb begin
    st_o = st_i;
    rem  = st_i.rem;
    num  = st_i.num;
    r2   = '0;
    if (st_i.op == OP_DIV) begin
      for (int i = 0; i < STEPS_PER_STAGE; i++) begin
        r2  = {rem, num[QW-1]};
        num = {num[QW-2:0], 1'b0};
        if (r2 >= {1'b0, st_i.dvs}) begin
          r2     = r2 - {1'b0, st_i.dvs};
          num[0] = 1'b1;
        end
        rem = r2[DW-1:0];
      end
      st_o.rem = rem;
      st_o.num = num;
    end
  end

endmodule

`default_nettype wire

// File: rtl/fixed_point_alu_q24_8.sv
// Q24.8 arithmetic unit, top level: a 10-stage pipeline that accepts one word
// per cycle while no stall backs up to its input, and returns one result word
// per request, in order. The depth is set by the divider: 40 restoring
// quotient steps, five per stage, over eight stages, plus a setup stage in
// front and a sign-fix stage that is also the output register.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled output only backs up as far as the pipeline is full.
// Depends on fpa_pkg, fpa_front, fpa_pack, fpa_div_steps.
`default_nettype none

module fixed_point_alu_q24_8 (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire fpa_pkg::fpa_req_t in_req_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      fpa_pkg::fpa_rsp_t out_rsp_o
);
  import fpa_pkg::*;

  localparam int unsigned LAST = NUM_STAGES - 1;

  fpa_st_t                 st_q [NUM_STAGES];
  fpa_st_t                 st_d [NUM_STAGES];
  fpa_st_t                 div_in [DIV_STAGES];
  fpa_st_t                 front_st, pack_st;
  logic [NUM_STAGES-1:0]   vld_q, vld_d, adv;
  logic [DW-1:0]           quo;

  // Stage 0: decode and the simple ops.
  fpa_front u_front (
    .req_i (in_req_i),
    .st_o  (front_st)
  );
  assign st_d[0] = front_st;

  // Finish multiply and fixed-to-float on the way into the divider.
  fpa_pack u_pack (
    .st_i (st_q[0]),
    .st_o (pack_st)
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    if (g == 0) begin : g_first
      assign div_in[g] = pack_st;
    end else begin : g_rest
      assign div_in[g] = st_q[g];
    end
    fpa_div_steps u_div (
      .st_i (div_in[g]),
      .st_o (st_d[g+1])
    );
  end

  // Last stage: apply the quotient sign, zero the result on a zero divisor.
  always_comb begin
    st_d[LAST] = st_q[LAST-1];
    quo        = st_q[LAST-1].num[DW-1:0];
    if (st_q[LAST-1].op == OP_DIV) begin
      st_d[LAST].res = st_q[LAST-1].dz ? '0
                     : (st_q[LAST-1].neg ? (DW'(0) - quo) : quo);
    end
  end

  // Advance a stage when it is empty or its successor takes its word.
  always_comb begin
    adv[LAST] = !vld_q[LAST] || out_ready_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vld_d = {vld_q[LAST-1:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (adv[k]) vld_q[k] <= vld_d[k];
      end
    end
  end

  // Payload carries no reset; hold it whenever the stage stalls.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (adv[k]) st_q[k] <= st_d[k];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[LAST];

  always_comb begin
    out_rsp_o.result_value   = st_q[LAST].res;
    out_rsp_o.divide_by_zero = st_q[LAST].dz;
  end

endmodule

`default_nettype wire

// File: rtl/fpa_checker.sv
// Port-level assertions for the Q24.8 arithmetic unit, bound to the top level.
// Depends on fpa_pkg and fixed_point_alu_q24_8_assert.svh.
`default_nettype none

`include "fixed_point_alu_q24_8_assert.svh"

module fpa_port_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire fpa_pkg::fpa_rsp_t out_rsp_o
);

  // Hold a stalled result word.
  `FPA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "output word dropped")
  `FPA_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_rsp_o), "output word changed")
  // A drained or draining tail frees the whole pipe for a new word.
  `FPA_ASSERT_NOW(a_in_free, !out_valid_o || out_ready_i, in_ready_o, "input blocked needlessly")
  // A divide by zero always reports a zero result.
  `FPA_ASSERT_NOW(a_dz_zero, out_valid_o && out_rsp_o.divide_by_zero, out_rsp_o.result_value == 0, "dz with nonzero result")

endmodule

bind fixed_point_alu_q24_8 fpa_port_checker u_fpa_checker (.*);

`default_nettype wire
